### hdl/vsfm_pkg.sv
// ----------------------------------------------------------------------------
// vsfm_pkg
// shared types and constants of the vital sign frame monitor
// ----------------------------------------------------------------------------
package vsfm_pkg;

    localparam int FRAME_BYTES = 12;
    localparam int POS_W       = $clog2(FRAME_BYTES + 1);
    localparam int N_CHECKS    = 6;
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 32;

    localparam logic [7:0] HDR_BYTE    = 8'hAA;
    localparam logic [7:0] TAIL_BYTE   = 8'h55;
    localparam logic [7:0] TYPE_HEALTH = 8'h01;
    localparam logic [7:0] TYPE_FALL   = 8'h02;
    localparam logic [7:0] TYPE_ENV    = 8'h03;

    localparam logic [CFG_IDX_W-1:0] REG_HR_LOW    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_HR_HIGH   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_OX_LOW    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_TEMP_LOW  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_TEMP_HIGH = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_PM_HIGH   = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_STREAK    = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_COOLDOWN  = 3'd7;

    localparam logic [2:0] EV_ACCEPT  = 3'd0;
    localparam logic [2:0] EV_BADTAIL = 3'd1;
    localparam logic [2:0] EV_BADSUM  = 3'd2;
    localparam logic [2:0] EV_FALL    = 3'd3;
    localparam logic [2:0] EV_ANOMALY = 3'd4;

    // frame handed from the front part to the back part
    typedef struct packed {
        logic [7:0]  ptype;
        logic [63:0] body;
        logic        bad_tail;
        logic        bad_sum;
        logic [31:0] tick;
    } frame_t;

    typedef struct packed {
        logic [2:0]  event_kind;
        logic [7:0]  packet_type;
        logic [63:0] payload;
        logic [2:0]  anomaly_code;
        logic [16:0] reading;
        logic [31:0] fall_time;
        logic        last;
    } result_t;

    typedef struct packed {
        logic [7:0]  hr_low;
        logic [7:0]  hr_high;
        logic [7:0]  ox_low;
        logic [15:0] temp_low;
        logic [15:0] temp_high;
        logic [15:0] pm_high;
        logic [7:0]  streak_need;
        logic [31:0] cooldown;
    } cfg_t;

endpackage

### hdl/vsfm_front.sv
// ----------------------------------------------------------------------------
// vsfm_front
// frame hunter: collects bytes, checks tail and checksum, counts ticks
// ----------------------------------------------------------------------------
module vsfm_front
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    input  logic              action,
    input  logic [7:0]        rx_byte,
    output logic              frame_valid,
    output vsfm_pkg::frame_t  frame
);
    import vsfm_pkg::*;

    logic [POS_W-1:0] pos_reg;
    logic [7:0]       type_reg;
    logic [63:0]      body_reg;
    logic [7:0]       xor_reg;
    logic             sum_bad_reg;
    logic [31:0]      tick_reg;
    logic             take;
    logic [POS_W-1:0] pos_next;

    assign take = in_valid && !action && (pos_reg != '0 || rx_byte == HDR_BYTE);
    assign pos_next = pos_reg + POS_W'(1);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg     <= '0;
            tick_reg    <= '0;
            xor_reg     <= '0;
            sum_bad_reg <= 1'b0;
        end
        else
        begin
            if (in_valid && action)
                tick_reg <= tick_reg + 32'd1;
            if (take)
            begin
                if (pos_next == POS_W'(FRAME_BYTES))
                    pos_reg <= '0;
                else
                    pos_reg <= pos_next;
                if (pos_reg == '0)
                    xor_reg <= rx_byte;
                else if (pos_reg < POS_W'(10))
                    xor_reg <= xor_reg ^ rx_byte;
                if (pos_reg == POS_W'(10))
                    sum_bad_reg <= (xor_reg != rx_byte);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (take && pos_reg == POS_W'(1))
            type_reg <= rx_byte;
        if (take && pos_reg >= POS_W'(2) && pos_reg <= POS_W'(9))
            body_reg <= {rx_byte, body_reg[63:8]};
    end

    assign frame_valid    = take && pos_reg == POS_W'(FRAME_BYTES - 1);
    assign frame.ptype    = type_reg;
    assign frame.body     = body_reg;
    assign frame.bad_tail = rx_byte != TAIL_BYTE;
    assign frame.bad_sum  = sum_bad_reg;
    assign frame.tick     = tick_reg;

endmodule

### hdl/vsfm_fifo.sv
// ----------------------------------------------------------------------------
// vsfm_fifo
// small register queue of words
// ----------------------------------------------------------------------------
module vsfm_fifo
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              wr_en,
    input  vsfm_pkg::result_t wr_data,
    input  logic              rd_en,
    output vsfm_pkg::result_t rd_data,
    output logic              empty,
    output logic [4:0]        count
);
    import vsfm_pkg::*;

    localparam int DEPTH = 16;

    result_t    mem_reg [DEPTH];
    logic [3:0] wp_reg;
    logic [3:0] rp_reg;
    logic [4:0] cnt_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= '0;
            rp_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            if (wr_en)
                wp_reg <= wp_reg + 4'd1;
            if (rd_en)
                rp_reg <= rp_reg + 4'd1;
            cnt_reg <= cnt_reg + 5'(wr_en) - 5'(rd_en);
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem_reg[wp_reg] <= wr_data;
    end

    assign rd_data = mem_reg[rp_reg];
    assign empty   = cnt_reg == '0;
    assign count   = cnt_reg;

endmodule

### hdl/vsfm_back.sv
// ----------------------------------------------------------------------------
// vsfm_back
// frame executor: updates readings, fall and streak state, emits words
// ----------------------------------------------------------------------------
module vsfm_back
(
    input  logic              clk,
    input  logic              rst_n,
    input  vsfm_pkg::cfg_t    cfg,
    input  logic              frame_valid,
    input  vsfm_pkg::frame_t  frame,
    output logic              busy,
    output logic              res_valid,
    output vsfm_pkg::result_t res
);
    import vsfm_pkg::*;

    typedef enum logic [3:0] {
        ST_IDLE  = 4'b0001,
        ST_CHECK = 4'b0010,
        ST_FALL  = 4'b0100,
        ST_EMIT  = 4'b1000
    } state_t;

    state_t      state_reg;
    frame_t      fr_reg;
    logic [7:0]  hr_reg, ox_reg;
    logic [15:0] temp_reg, pm_reg;
    logic        fall_reg;
    logic [31:0] fall_rep_reg;
    logic        fall_pend_reg;
    logic [2:0]  left_reg;
    logic [7:0]  streak_reg [N_CHECKS];
    logic [31:0] atick_reg [N_CHECKS];
    logic [N_CHECKS-1:0] seen_reg;
    logic [N_CHECKS-1:0] fire_reg;
    logic        do_check_reg;

    // stage 1: word for the frame event, fall, readings
    logic        ok;
    logic        fall_emit;
    logic        fall_set;
    logic        go_check;
    logic        any_fire;
    logic        emit_last;
    logic [N_CHECKS-1:0] active, trip;
    logic [7:0]  need;
    logic [N_CHECKS-1:0] fire_next;
    logic [7:0]  sc_next [N_CHECKS];
    logic [16:0] rd_val [N_CHECKS];
    logic [2:0]  code_sel;
    logic [N_CHECKS-1:0] fire_left;

    assign ok = !frame.bad_tail && !frame.bad_sum;

    always_comb
    begin
        fall_set  = 1'b0;
        fall_emit = 1'b0;
        if (ok && frame.ptype == TYPE_HEALTH)
        begin
            fall_set  = (frame.body[39:32] != 8'd0) && !fall_reg;
            fall_emit = fall_set && frame.tick != fall_rep_reg;
        end
        else if (ok && frame.ptype == TYPE_FALL)
            fall_emit = frame.tick != fall_rep_reg;
    end

    assign go_check = ok && (frame.ptype == TYPE_HEALTH || frame.ptype == TYPE_ENV
                             || fall_emit);

    always_comb
    begin
        need = (cfg.streak_need == 8'd0) ? 8'd1 : cfg.streak_need;
        active[0] = hr_reg != 8'd0;
        active[1] = hr_reg != 8'd0;
        active[2] = ox_reg != 8'd0;
        active[3] = $signed(temp_reg) > 16'sd0;
        active[4] = $signed(temp_reg) > 16'sd0;
        active[5] = pm_reg != 16'd0;
        trip[0] = hr_reg < cfg.hr_low;
        trip[1] = hr_reg > cfg.hr_high;
        trip[2] = ox_reg < cfg.ox_low;
        trip[3] = $signed(temp_reg) < $signed(cfg.temp_low);
        trip[4] = $signed(temp_reg) > $signed(cfg.temp_high);
        trip[5] = pm_reg > cfg.pm_high;
        rd_val[0] = {9'd0, hr_reg};
        rd_val[1] = {9'd0, hr_reg};
        rd_val[2] = {9'd0, ox_reg};
        rd_val[3] = {temp_reg[15], temp_reg};
        rd_val[4] = {temp_reg[15], temp_reg};
        rd_val[5] = {1'b0, pm_reg};
        for (int k = 0; k < N_CHECKS; k++)
        begin
            if (!trip[k])
                sc_next[k] = 8'd0;
            else if (streak_reg[k] != 8'd255)
                sc_next[k] = streak_reg[k] + 8'd1;
            else
                sc_next[k] = streak_reg[k];
            fire_next[k] = active[k] && trip[k] && sc_next[k] >= need &&
                           !(seen_reg[k] && (fr_reg.tick - atick_reg[k]) < cfg.cooldown);
        end
    end

    assign any_fire = do_check_reg && fire_next != '0;

    // lowest pending alarm
    always_comb
    begin
        code_sel = 3'd0;
        for (int k = N_CHECKS - 1; k >= 0; k--)
            if (fire_reg[k])
                code_sel = 3'(k);
        fire_left = fire_reg & ~(N_CHECKS'(1) << code_sel);
    end

    // at most six words per frame
    assign emit_last = fire_left == '0 || left_reg == 3'd1;

    assign busy = state_reg != ST_IDLE;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            fr_reg        <= '0;
            hr_reg        <= '0;
            ox_reg        <= '0;
            temp_reg      <= '0;
            pm_reg        <= '0;
            fall_reg      <= 1'b0;
            fall_rep_reg  <= '0;
            fall_pend_reg <= 1'b0;
            left_reg      <= '0;
            seen_reg      <= '0;
            fire_reg      <= '0;
            do_check_reg  <= 1'b0;
            res_valid     <= 1'b0;
            res           <= '0;
            for (int k = 0; k < N_CHECKS; k++)
            begin
                streak_reg[k] <= '0;
                atick_reg[k]  <= '0;
            end
        end
        else
        begin
            unique case (state_reg)
                ST_IDLE:
                begin
                    res_valid <= frame_valid && !go_check;
                    if (frame_valid)
                    begin
                        res.packet_type  <= frame.ptype;
                        res.anomaly_code <= '0;
                        res.reading      <= '0;
                        res.fall_time    <= '0;
                        res.payload      <= ok ? frame.body : '0;
                        res.last         <= 1'b1;
                        if (frame.bad_tail)
                            res.event_kind <= EV_BADTAIL;
                        else if (frame.bad_sum)
                            res.event_kind <= EV_BADSUM;
                        else
                            res.event_kind <= EV_ACCEPT;
                        do_check_reg <= ok && (frame.ptype == TYPE_HEALTH ||
                                               frame.ptype == TYPE_ENV);
                        if (ok && frame.ptype == TYPE_HEALTH)
                        begin
                            hr_reg   <= frame.body[7:0];
                            ox_reg   <= frame.body[15:8];
                            temp_reg <= frame.body[31:16];
                            fall_reg <= frame.body[39:32] != 8'd0;
                        end
                        if (ok && frame.ptype == TYPE_ENV)
                            pm_reg <= frame.body[15:0];
                        if (ok && frame.ptype == TYPE_FALL)
                            fall_reg <= 1'b1;
                        if (fall_emit)
                            fall_rep_reg <= frame.tick;
                        fr_reg        <= frame;
                        fall_pend_reg <= fall_emit;
                        if (go_check)
                            state_reg <= ST_CHECK;
                    end
                end
                ST_CHECK:
                begin
                    res_valid <= 1'b1;
                    res.last  <= !(fall_pend_reg || any_fire);
                    left_reg  <= fall_pend_reg ? 3'd4 : 3'd5;
                    fire_reg  <= do_check_reg ? fire_next : '0;
                    if (do_check_reg)
                    begin
                        for (int k = 0; k < N_CHECKS; k++)
                            if (active[k])
                            begin
                                streak_reg[k] <= sc_next[k];
                                if (fire_next[k])
                                begin
                                    atick_reg[k] <= fr_reg.tick;
                                    seen_reg[k]  <= 1'b1;
                                end
                            end
                    end
                    if (fall_pend_reg)
                        state_reg <= ST_FALL;
                    else if (any_fire)
                        state_reg <= ST_EMIT;
                    else
                        state_reg <= ST_IDLE;
                end
                ST_FALL:
                begin
                    res_valid        <= 1'b1;
                    res.event_kind   <= EV_FALL;
                    res.packet_type  <= fr_reg.ptype;
                    res.payload      <= '0;
                    res.anomaly_code <= '0;
                    res.reading      <= '0;
                    res.fall_time    <= fr_reg.tick;
                    res.last         <= fire_reg == '0;
                    if (fire_reg != '0)
                        state_reg <= ST_EMIT;
                    else
                        state_reg <= ST_IDLE;
                end
                ST_EMIT:
                begin
                    res_valid        <= 1'b1;
                    res.event_kind   <= EV_ANOMALY;
                    res.packet_type  <= fr_reg.ptype;
                    res.payload      <= '0;
                    res.anomaly_code <= code_sel;
                    res.reading      <= rd_val[code_sel];
                    res.fall_time    <= '0;
                    res.last         <= emit_last;
                    fire_reg         <= fire_left;
                    left_reg         <= left_reg - 3'd1;
                    if (emit_last)
                        state_reg <= ST_IDLE;
                end
                default:
                begin
                    res_valid <= 1'b0;
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

`ifndef SYNTHESIS
    a_emit_has_fire: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_EMIT |-> fire_reg != '0)
        else $error("emit state with no pending alarm");
    a_emit_room: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_EMIT |-> left_reg != 3'd0)
        else $error("emit state with no word budget left");
    a_fall_word: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res.event_kind == EV_FALL |-> res.fall_time == fall_rep_reg)
        else $error("fall word time differs from reported tick");
    a_streak_sat: assert property (@(posedge clk) disable iff (!rst_n)
        $past(streak_reg[0]) == 8'd255 && streak_reg[0] != 8'd255 |-> streak_reg[0] == 8'd0)
        else $error("streak counter wrapped");
`endif

endmodule

### hdl/vital_sign_frame_monitor_core.sv
// ----------------------------------------------------------------------------
// vital_sign_frame_monitor_core
// uart frame monitor for vital sign and environment frames
// ----------------------------------------------------------------------------
// Input queue side: push with action/rx_byte; a word is taken when push is
// high and full is low. Bytes and ticks can follow back to back. A
// completed frame travels straight to the back part.
// Result queue side: while empty is low the oldest result word is on the
// result ports; pop takes it. A frame yields up to six words. A frame with
// no further words has its event word registered in the back part, then
// queued; health and environment frames, and fall frames with a new tick,
// pass a check step that sends it, then the fall alarm and the anomaly
// words follow one per cycle. The back part is busy only while it sends
// a frame's words, which the twelve bytes of the next frame always cover.
// Results wait in a 16-word queue; full rises while more than eight words
// wait, so a stalled receiver only stops intake.
// Reset clears the hunt, tick counter, readings, fall and streak state and
// loads the default limits; the queue comes up empty.
// Configuration: cfg_we writes cfg_data to register cfg_index at once.
// ----------------------------------------------------------------------------
module vital_sign_frame_monitor_core
(
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             push,
    output logic                             full,
    input  logic                             action,
    input  logic [7:0]                       rx_byte,
    output logic                             empty,
    input  logic                             pop,
    output logic [2:0]                       event_kind,
    output logic [7:0]                       packet_type,
    output logic [63:0]                      payload,
    output logic [2:0]                       anomaly_code,
    output logic signed [16:0]               reading,
    output logic [31:0]                      fall_time,
    output logic                             last,
    input  logic                             cfg_we,
    input  logic [vsfm_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [vsfm_pkg::CFG_DATA_W-1:0]  cfg_data
);
    import vsfm_pkg::*;

    cfg_t    cfg_reg;
    frame_t  frame;
    logic    frame_valid;
    logic    busy;
    logic    res_valid;
    result_t res;
    result_t q_out;
    logic [4:0] q_count;
    logic    accept;
    logic    deq;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.hr_low      <= 8'd50;
            cfg_reg.hr_high     <= 8'd120;
            cfg_reg.ox_low      <= 8'd92;
            cfg_reg.temp_low    <= 16'd3500;
            cfg_reg.temp_high   <= 16'd3800;
            cfg_reg.pm_high     <= 16'd750;
            cfg_reg.streak_need <= 8'd3;
            cfg_reg.cooldown    <= 32'd60000;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_HR_LOW:    cfg_reg.hr_low      <= cfg_data[7:0];
                REG_HR_HIGH:   cfg_reg.hr_high     <= cfg_data[7:0];
                REG_OX_LOW:    cfg_reg.ox_low      <= cfg_data[7:0];
                REG_TEMP_LOW:  cfg_reg.temp_low    <= cfg_data[15:0];
                REG_TEMP_HIGH: cfg_reg.temp_high   <= cfg_data[15:0];
                REG_PM_HIGH:   cfg_reg.pm_high     <= cfg_data[15:0];
                REG_STREAK:    cfg_reg.streak_need <= cfg_data[7:0];
                REG_COOLDOWN:  cfg_reg.cooldown    <= cfg_data;
                default: ;
            endcase
        end
    end

    // room for the words of one frame
    assign full   = q_count > 5'd8;
    assign accept = push && !full;
    assign deq    = pop && !empty;

    vsfm_front u_front
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (accept),
        .action      (action),
        .rx_byte     (rx_byte),
        .frame_valid (frame_valid),
        .frame       (frame)
    );

    vsfm_back u_back
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg         (cfg_reg),
        .frame_valid (frame_valid),
        .frame       (frame),
        .busy        (busy),
        .res_valid   (res_valid),
        .res         (res)
    );

    vsfm_fifo u_fifo
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (res_valid),
        .wr_data (res),
        .rd_en   (deq),
        .rd_data (q_out),
        .empty   (empty),
        .count   (q_count)
    );

    assign event_kind   = q_out.event_kind;
    assign packet_type  = q_out.packet_type;
    assign payload      = q_out.payload;
    assign anomaly_code = q_out.anomaly_code;
    assign reading      = q_out.reading;
    assign fall_time    = q_out.fall_time;
    assign last         = q_out.last;

`ifndef SYNTHESIS
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> q_count < 5'd16 || deq)
        else $error("result queue overflow");
    a_frame_idle: assert property (@(posedge clk) disable iff (!rst_n)
        frame_valid |-> !busy)
        else $error("frame arrived while back part busy");
    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        q_count <= 5'd16)
        else $error("result queue count out of range");
`endif

endmodule
